// File: sv/mfu_pkg.sv
// ----------------------------------------------------------------------------
// MFU page replacement package
// Shared constants, handshake structs and the controller state type.
// ----------------------------------------------------------------------------
package mfu_pkg;

   // Fixed port widths and the width of the frame limit compare.
   localparam int PAGE_NUM_W  = 16;
   localparam int FRAME_IDX_W = 4;
   localparam int FAULT_W     = 16;
   localparam int CFG_W       = 5;
   localparam int LIM_W       = 7;

   localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
   localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

   // Flags that travel with the search word along the row of cells.
   typedef struct packed {
      logic valid;
      logic hit;
      logic empty;
      logic max_seen;
   } scan_flags_type;

   // Write command broadcast to the cells after a search completes.
   typedef struct packed {
      logic en;
      logic insert;
   } upd_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

endpackage

// File: sv/mfu_cell.sv
// ----------------------------------------------------------------------------
// MFU frame cell
// Holds one frame and folds it into the search word that passes by.
// ----------------------------------------------------------------------------
module mfu_cell #(
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16,
   parameter int IDX_W      = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    active,
   input  mfu_pkg::scan_flags_type flags_in,
   input  logic [PAGE_BITS-1:0]    page_in,
   input  logic [IDX_W-1:0]        hit_idx_in,
   input  logic [IDX_W-1:0]        empty_idx_in,
   input  logic [IDX_W-1:0]        max_idx_in,
   input  logic [COUNT_BITS-1:0]   max_count_in,
   input  logic [PAGE_BITS-1:0]    max_page_in,
   output mfu_pkg::scan_flags_type flags_out,
   output logic [PAGE_BITS-1:0]    page_out,
   output logic [IDX_W-1:0]        hit_idx_out,
   output logic [IDX_W-1:0]        empty_idx_out,
   output logic [IDX_W-1:0]        max_idx_out,
   output logic [COUNT_BITS-1:0]   max_count_out,
   output logic [PAGE_BITS-1:0]    max_page_out,
   input  mfu_pkg::upd_cmd_type    upd,
   input  logic [IDX_W-1:0]        upd_idx,
   input  logic [PAGE_BITS-1:0]    upd_page
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic                  valid_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic [COUNT_BITS-1:0] count_ff;

   mfu_pkg::scan_flags_type flags_ff, flags_in_nxt;
   logic [PAGE_BITS-1:0]    page_out_ff, max_page_ff, max_page_in_nxt;
   logic [IDX_W-1:0]        hit_idx_ff, empty_idx_ff, max_idx_ff;
   logic [IDX_W-1:0]        hit_idx_in_nxt, empty_idx_in_nxt, max_idx_in_nxt;
   logic [COUNT_BITS-1:0]   max_count_ff, max_count_in_nxt;
   logic                    match, take_max;

   // Fold this frame into the passing search word.
   always_comb begin
      match    = active && valid_ff && (page_ff == page_in);
      take_max = active && (!flags_in.max_seen || (count_ff > max_count_in));

      flags_in_nxt     = flags_in;
      hit_idx_in_nxt   = hit_idx_in;
      empty_idx_in_nxt = empty_idx_in;
      max_idx_in_nxt   = max_idx_in;
      max_count_in_nxt = max_count_in;
      max_page_in_nxt  = max_page_in;

      if (!flags_in.hit && match) begin
         flags_in_nxt.hit = 1'b1;
         hit_idx_in_nxt   = MY_IDX;
      end
      if (!flags_in.empty && active && !valid_ff) begin
         flags_in_nxt.empty = 1'b1;
         empty_idx_in_nxt   = MY_IDX;
      end
      if (take_max) begin
         flags_in_nxt.max_seen = 1'b1;
         max_idx_in_nxt        = MY_IDX;
         max_count_in_nxt      = count_ff;
         max_page_in_nxt       = page_ff;
      end
   end

   // Hand the search word to the next cell; payload holds between words.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff.valid <= 1'b0;
      end else begin
         flags_ff.valid <= flags_in.valid;
      end
      if (flags_in.valid) begin
         flags_ff.hit      <= flags_in_nxt.hit;
         flags_ff.empty    <= flags_in_nxt.empty;
         flags_ff.max_seen <= flags_in_nxt.max_seen;
         page_out_ff       <= page_in;
         hit_idx_ff        <= hit_idx_in_nxt;
         empty_idx_ff      <= empty_idx_in_nxt;
         max_idx_ff        <= max_idx_in_nxt;
         max_count_ff      <= max_count_in_nxt;
         max_page_ff       <= max_page_in_nxt;
      end
   end

   // Frame contents: insert a new page or bump the use count.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (upd.en && (upd_idx == MY_IDX) && upd.insert) begin
         valid_ff <= 1'b1;
      end
      if (upd.en && (upd_idx == MY_IDX)) begin
         if (upd.insert) begin
            page_ff  <= upd_page;
            count_ff <= COUNT_BITS'(1);
         end else if (count_ff != '1) begin
            count_ff <= count_ff + COUNT_BITS'(1);
         end
      end
   end

   assign flags_out     = flags_ff;
   assign page_out      = page_out_ff;
   assign hit_idx_out   = hit_idx_ff;
   assign empty_idx_out = empty_idx_ff;
   assign max_idx_out   = max_idx_ff;
   assign max_count_out = max_count_ff;
   assign max_page_out  = max_page_ff;

endmodule

// File: sv/mfu_ctrl.sv
// ----------------------------------------------------------------------------
// MFU controller
// Launches searches, picks the frame to write and holds the result word.
// ----------------------------------------------------------------------------
module mfu_ctrl #(
   parameter int PAGE_BITS = 16,
   parameter int IDX_W     = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    launch,
   input  mfu_pkg::scan_flags_type tail_flags,
   input  logic [IDX_W-1:0]        tail_hit_idx,
   input  logic [IDX_W-1:0]        tail_empty_idx,
   input  logic [IDX_W-1:0]        tail_max_idx,
   input  logic [PAGE_BITS-1:0]    tail_max_page,
   output mfu_pkg::upd_cmd_type    upd,
   output logic [IDX_W-1:0]        upd_idx,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_hit,
   output logic [mfu_pkg::FRAME_IDX_W-1:0] rsp_frame_index,
   output logic                    rsp_evicted_valid,
   output logic [mfu_pkg::PAGE_NUM_W-1:0]  rsp_evicted_page,
   output logic [mfu_pkg::FAULT_W-1:0]     rsp_fault_total
);

   mfu_pkg::state_type state_ff, state_in;

   logic                           rsp_valid_ff;
   logic                           rsp_hit_ff;
   logic [mfu_pkg::FRAME_IDX_W-1:0] rsp_frame_ff;
   logic                           rsp_ev_valid_ff;
   logic [mfu_pkg::PAGE_NUM_W-1:0] rsp_ev_page_ff;
   logic [mfu_pkg::FAULT_W-1:0]    faults_ff, faults_in;
   logic                           out_free;
   logic [IDX_W-1:0]               slot;
   logic                           ev_valid;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfu_pkg::ST_IDLE:  if (req_valid) state_in = mfu_pkg::ST_SCAN;
         mfu_pkg::ST_SCAN:  if (tail_flags.valid) state_in = mfu_pkg::ST_WRITE;
         mfu_pkg::ST_WRITE: if (out_free) state_in = mfu_pkg::ST_IDLE;
         default:           state_in = mfu_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready  = 1'b0;
      launch     = 1'b0;
      upd.en     = 1'b0;
      upd.insert = !tail_flags.hit;
      unique case (state_ff)
         mfu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            launch    = req_valid;
         end
         mfu_pkg::ST_SCAN: begin
         end
         mfu_pkg::ST_WRITE: begin
            upd.en = out_free;
         end
         default: begin
         end
      endcase
   end

   // Pick the frame: hit, else first empty, else the most used.
   always_comb begin
      ev_valid = 1'b0;
      if (tail_flags.hit) begin
         slot = tail_hit_idx;
      end else if (tail_flags.empty) begin
         slot = tail_empty_idx;
      end else begin
         slot     = tail_max_idx;
         ev_valid = 1'b1;
      end
      upd_idx = slot;
   end

   // Fault total saturates.
   always_comb begin
      faults_in = faults_ff;
      if (!tail_flags.hit && (faults_ff != mfu_pkg::FAULT_MAX)) begin
         faults_in = faults_ff + mfu_pkg::FAULT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         faults_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (upd.en) begin
            rsp_valid_ff <= 1'b1;
            faults_ff    <= faults_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (upd.en) begin
         rsp_hit_ff      <= tail_flags.hit;
         rsp_frame_ff    <= mfu_pkg::FRAME_IDX_W'(slot);
         rsp_ev_valid_ff <= ev_valid;
         rsp_ev_page_ff  <= ev_valid ? mfu_pkg::PAGE_NUM_W'(tail_max_page) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = faults_ff;

   // A search word only leaves the row while the controller waits for it.
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail_flags.valid |-> state_ff == mfu_pkg::ST_SCAN)
      else $error("search word left the row outside of a scan");

   // An accepted word starts a scan in the next cycle.
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == mfu_pkg::ST_SCAN)
      else $error("accepted word did not start a scan");

   // The fault total never goes down.
   a_fault_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> faults_ff >= $past(faults_ff))
      else $error("fault total decreased");

   // A write may not be issued while a result still waits unread.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      upd.en |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

// File: sv/mfu_page_replacement.sv
// ----------------------------------------------------------------------------
// MFU page replacement
// Most-frequently-used page frame manager built as a row of frame cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one page reference per word (valid/ready). rsp_* returns
//   one word per reference: hit flag, frame index, evicted page and the
//   saturating fault total. csr_* writes frames_in_use; it is always ready
//   and should be written only while no reference is outstanding.
// Timing:
//   A search word walks the row of NUM_FRAMES cells one cell per cycle;
//   the last cell hands it to the controller, whose write step registers
//   the result word. One reference is in flight at a time, so a new
//   reference is taken only once the previous one has left the write
//   step. The result register lets the next reference be taken while
//   the previous result is still waiting.
// Reset and stalls:
//   Reset empties all frames, clears the fault total and sets
//   frames_in_use to 16; no clearing pass is needed. If rsp_ready stays
//   low, the finished search waits in the write step until the result
//   register frees up, and no new reference is accepted in the meantime.
// ----------------------------------------------------------------------------
module mfu_page_replacement #(
   parameter int NUM_FRAMES = 16,
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mfu_pkg::CFG_W-1:0]         csr_frames_in_use,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mfu_pkg::PAGE_NUM_W-1:0]    req_page_number,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [mfu_pkg::FRAME_IDX_W-1:0]   rsp_frame_index,
   output logic                              rsp_evicted_valid,
   output logic [mfu_pkg::PAGE_NUM_W-1:0]    rsp_evicted_page,
   output logic [mfu_pkg::FAULT_W-1:0]       rsp_fault_total
);

   localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

   logic [mfu_pkg::CFG_W-1:0] frames_ff;
   logic [NUM_FRAMES-1:0]     active;
   logic                      launch;
   mfu_pkg::upd_cmd_type      upd;
   logic [IDX_W-1:0]          upd_idx;

   mfu_pkg::scan_flags_type   flags_c     [NUM_FRAMES+1];
   logic [PAGE_BITS-1:0]      page_c      [NUM_FRAMES+1];
   logic [IDX_W-1:0]          hit_idx_c   [NUM_FRAMES+1];
   logic [IDX_W-1:0]          empty_idx_c [NUM_FRAMES+1];
   logic [IDX_W-1:0]          max_idx_c   [NUM_FRAMES+1];
   logic [COUNT_BITS-1:0]     max_count_c [NUM_FRAMES+1];
   logic [PAGE_BITS-1:0]      max_page_c  [NUM_FRAMES+1];

   // Configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= mfu_pkg::CFG_RESET;
      end else if (csr_valid) begin
         frames_ff <= csr_frames_in_use;
      end
   end

   // Head of the row: a fresh search word.
   assign flags_c[0]     = '{valid: launch, default: 1'b0};
   assign page_c[0]      = PAGE_BITS'(req_page_number);
   assign hit_idx_c[0]   = '0;
   assign empty_idx_c[0] = '0;
   assign max_idx_c[0]   = '0;
   assign max_count_c[0] = '0;
   assign max_page_c[0]  = '0;

   // Row of frame cells; a zero setting acts as one frame.
   for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
      assign active[i] = (frames_ff == '0) ? (i == 0) :
                         (mfu_pkg::LIM_W'(i) < mfu_pkg::LIM_W'(frames_ff));

      mfu_cell #(
         .PAGE_BITS  (PAGE_BITS),
         .COUNT_BITS (COUNT_BITS),
         .IDX_W      (IDX_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .active        (active[i]),
         .flags_in      (flags_c[i]),
         .page_in       (page_c[i]),
         .hit_idx_in    (hit_idx_c[i]),
         .empty_idx_in  (empty_idx_c[i]),
         .max_idx_in    (max_idx_c[i]),
         .max_count_in  (max_count_c[i]),
         .max_page_in   (max_page_c[i]),
         .flags_out     (flags_c[i+1]),
         .page_out      (page_c[i+1]),
         .hit_idx_out   (hit_idx_c[i+1]),
         .empty_idx_out (empty_idx_c[i+1]),
         .max_idx_out   (max_idx_c[i+1]),
         .max_count_out (max_count_c[i+1]),
         .max_page_out  (max_page_c[i+1]),
         .upd           (upd),
         .upd_idx       (upd_idx),
         .upd_page      (page_c[NUM_FRAMES])
      );
   end

   // Controller at the tail of the row.
   mfu_ctrl #(
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IDX_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .launch            (launch),
      .tail_flags        (flags_c[NUM_FRAMES]),
      .tail_hit_idx      (hit_idx_c[NUM_FRAMES]),
      .tail_empty_idx    (empty_idx_c[NUM_FRAMES]),
      .tail_max_idx      (max_idx_c[NUM_FRAMES]),
      .tail_max_page     (max_page_c[NUM_FRAMES]),
      .upd               (upd),
      .upd_idx           (upd_idx),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

endmodule
